// ===== rtl/core/lbmcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmcr_pkg
// Shared constants for the lattice Boltzmann collision core: register
// indexes, register widths and register reset values.
// ----------------------------------------------------------------------------
package lbmcr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int COEF_W      = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_TRT          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_EVEN         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_ODD          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORCE_WEIGHT_EVEN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORCE_WEIGHT_ODD  = 3'd4;

   localparam logic [COEF_W-1:0] RATE_EVEN_RST         = 31'd1073741824;
   localparam logic [COEF_W-1:0] RATE_ODD_RST          = 31'd1227133513;
   localparam logic [COEF_W-1:0] FORCE_WEIGHT_EVEN_RST = 31'd536870912;
   localparam logic [COEF_W-1:0] FORCE_WEIGHT_ODD_RST  = 31'd460175067;

endpackage

// ===== rtl/core/lbm_collision_relax_core.sv =====
`timescale 1ns / 1ps
// One item per cycle sustained while rsp_tready stays high; back-pressure holds full stages.
// Eight register stages, each with its own valid bit; a stage holds only while it is
// full and the stage after it cannot take its item, so bubbles are absorbed.
// The four coefficient products are split into two partial products each.
// Reset (synchronous) empties all stages and loads the register reset values.
// ----------------------------------------------------------------------------
// lbm_collision_relax_core
// BGK / TRT collision for one pair of opposite lattice directions, with
// forcing, arithmetic-shift rounding and output saturation.
// ----------------------------------------------------------------------------
module lbm_collision_relax_core
   import lbmcr_pkg::*;
#(
   parameter int DATA_WIDTH     = 32,
   parameter int RATE_FRAC_BITS = 30
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // csr write channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]                   csr_index,
   input  logic [COEF_W-1:0]                        csr_data,
   // request: tdata = f_dir, f_opp, eq_dir, eq_opp, force_dir, force_opp
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]        req_tdata,
   // request: tuser = is_rest
   input  logic                                     req_tuser,
   // response: tdata = f_dir_new, f_opp_new
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // response: tuser = saturated
   output logic                                     rsp_tuser
);

   localparam int DW    = DATA_WIDTH;
   localparam int RSP_W = ((2*DATA_WIDTH+7)/8)*8;
   localparam int NS    = 8;
   localparam int W1    = DW + 1;
   localparam int W2    = DW + 2;
   localparam int LO_B  = W2 / 2;
   localparam int HI_B  = W2 - LO_B;
   localparam int LOW   = LO_B + COEF_W;
   localparam int HIW   = HI_B + COEF_W + 1;
   localparam int PW    = W2 + COEF_W + 1;
   localparam int TW    = PW + 1;
   localparam int RW    = TW + 2;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic              mode_trt_ff;
   logic [COEF_W-1:0] rate_even_ff;
   logic [COEF_W-1:0] rate_odd_ff;
   logic [COEF_W-1:0] fw_even_ff;
   logic [COEF_W-1:0] fw_odd_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_trt_ff  <= 1'b0;
         rate_even_ff <= RATE_EVEN_RST;
         rate_odd_ff  <= RATE_ODD_RST;
         fw_even_ff   <= FORCE_WEIGHT_EVEN_RST;
         fw_odd_ff    <= FORCE_WEIGHT_ODD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE_TRT:          mode_trt_ff  <= csr_data[0];
            CSR_RATE_EVEN:         rate_even_ff <= csr_data;
            CSR_RATE_ODD:          rate_odd_ff  <= csr_data;
            CSR_FORCE_WEIGHT_EVEN: fw_even_ff   <= csr_data;
            CSR_FORCE_WEIGHT_ODD:  fw_odd_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // stage valids and per-stage ready
   // ------------------------------------------------------------------------
   logic [NS-1:0] valid_ff;
   logic [NS:0]   rdy;

   always_comb begin
      rdy[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = ~valid_ff[k] | rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = valid_ff[NS-1];

   // ------------------------------------------------------------------------
   // stage 1: capture the item
   // ------------------------------------------------------------------------
   logic signed [DW-1:0] s1_fd_in, s1_fo_in, s1_ed_in, s1_eo_in, s1_xd_in, s1_xo_in;
   logic signed [DW-1:0] s1_fd_ff, s1_fo_ff, s1_ed_ff, s1_eo_ff, s1_xd_ff, s1_xo_ff;
   logic                 s1_rest_ff;

   assign s1_fd_in = req_tdata[0*DW +: DW];
   assign s1_fo_in = req_tdata[1*DW +: DW];
   assign s1_ed_in = req_tdata[2*DW +: DW];
   assign s1_eo_in = req_tdata[3*DW +: DW];
   assign s1_xd_in = req_tdata[4*DW +: DW];
   assign s1_xo_in = req_tdata[5*DW +: DW];

   // ------------------------------------------------------------------------
   // stage 2: non-equilibrium parts and forcing sums
   // ------------------------------------------------------------------------
   logic signed [W1-1:0] s2_nd_in, s2_no_in, s2_sf_in, s2_df_in;
   logic signed [W1-1:0] s2_nd_ff, s2_no_ff, s2_sf_ff, s2_df_ff;
   logic signed [DW-1:0] s2_fd_ff, s2_fo_ff, s2_xd_ff, s2_xo_ff;
   logic                 s2_trt_in, s2_trt_ff, s2_rest_ff;

   assign s2_nd_in  = W1'(s1_fd_ff) - W1'(s1_ed_ff);
   assign s2_no_in  = W1'(s1_fo_ff) - W1'(s1_eo_ff);
   assign s2_sf_in  = W1'(s1_xd_ff) + W1'(s1_xo_ff);
   assign s2_df_in  = W1'(s1_xd_ff) - W1'(s1_xo_ff);
   // rest direction always takes the BGK path with the even registers
   assign s2_trt_in = mode_trt_ff & ~s1_rest_ff;

   // ------------------------------------------------------------------------
   // stage 3: select multiplicands and coefficients
   // order: lane 0 relax, lane 0 force, lane 1 relax, lane 1 force
   // ------------------------------------------------------------------------
   logic signed [W2-1:0] s3_op_in [4];
   logic signed [W2-1:0] s3_op_ff [4];
   logic [COEF_W-1:0]    s3_k_in  [4];
   logic [COEF_W-1:0]    s3_k_ff  [4];
   logic signed [DW-1:0] s3_fd_ff, s3_fo_ff;
   logic                 s3_trt_ff, s3_rest_ff;

   always_comb begin
      if (s2_trt_ff) begin
         s3_op_in[0] = W2'(s2_nd_ff) + W2'(s2_no_ff);
         s3_op_in[1] = W2'(s2_sf_ff);
         s3_op_in[2] = W2'(s2_nd_ff) - W2'(s2_no_ff);
         s3_op_in[3] = W2'(s2_df_ff);
         s3_k_in[2]  = rate_odd_ff;
         s3_k_in[3]  = fw_odd_ff;
      end else begin
         s3_op_in[0] = W2'(s2_nd_ff);
         s3_op_in[1] = W2'(s2_xd_ff);
         s3_op_in[2] = W2'(s2_no_ff);
         s3_op_in[3] = W2'(s2_xo_ff);
         s3_k_in[2]  = rate_even_ff;
         s3_k_in[3]  = fw_even_ff;
      end
      s3_k_in[0] = rate_even_ff;
      s3_k_in[1] = fw_even_ff;
   end

   // ------------------------------------------------------------------------
   // stage 4: partial products (low half unsigned, high half signed)
   // ------------------------------------------------------------------------
   logic [LOW-1:0]        s4_lo_in [4];
   logic [LOW-1:0]        s4_lo_ff [4];
   logic signed [HIW-1:0] s4_hi_in [4];
   logic signed [HIW-1:0] s4_hi_ff [4];
   logic signed [DW-1:0]  s4_fd_ff, s4_fo_ff;
   logic                  s4_trt_ff, s4_rest_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         s4_lo_in[j] = LOW'(s3_op_ff[j][LO_B-1:0]) * LOW'(s3_k_ff[j]);
         s4_hi_in[j] = HIW'($signed(s3_op_ff[j][W2-1:LO_B])) * $signed({1'b0, s3_k_ff[j]});
      end
   end

   // ------------------------------------------------------------------------
   // stage 5: recombine partial products
   // ------------------------------------------------------------------------
   logic signed [PW-1:0] s5_p_in [4];
   logic signed [PW-1:0] s5_p_ff [4];
   logic signed [DW-1:0] s5_fd_ff, s5_fo_ff;
   logic                 s5_trt_ff, s5_rest_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         s5_p_in[j] = (PW'(s4_hi_ff[j]) <<< LO_B) + PW'($signed({1'b0, s4_lo_ff[j]}));
      end
   end

   // ------------------------------------------------------------------------
   // stage 6: relaxation minus forcing per lane
   // ------------------------------------------------------------------------
   logic signed [TW-1:0] s6_t0_in, s6_t1_in, s6_t0_ff, s6_t1_ff;
   logic signed [DW-1:0] s6_fd_ff, s6_fo_ff;
   logic                 s6_trt_ff, s6_rest_ff;

   assign s6_t0_in = TW'(s5_p_ff[0]) - TW'(s5_p_ff[1]);
   assign s6_t1_in = TW'(s5_p_ff[2]) - TW'(s5_p_ff[3]);

   // ------------------------------------------------------------------------
   // stage 7: floor shift, subtract even part
   // TRT folds the factor one half into one more bit of shift
   // ------------------------------------------------------------------------
   logic signed [TW-1:0] s7_e0, s7_e1, s7_od;
   logic signed [RW-1:0] s7_u0_in, s7_u1_in, s7_d_in;
   logic signed [RW-1:0] s7_u0_ff, s7_u1_ff, s7_d_ff;
   logic                 s7_rest_ff;

   always_comb begin
      s7_od = s6_t1_ff >>> (RATE_FRAC_BITS + 1);
      if (s6_trt_ff) begin
         s7_e0   = s6_t0_ff >>> (RATE_FRAC_BITS + 1);
         s7_e1   = s7_e0;
         s7_d_in = RW'(s7_od);
      end else begin
         s7_e0   = s6_t0_ff >>> RATE_FRAC_BITS;
         s7_e1   = s6_t1_ff >>> RATE_FRAC_BITS;
         s7_d_in = '0;
      end
      s7_u0_in = RW'(s6_fd_ff) - RW'(s7_e0);
      s7_u1_in = RW'(s6_fo_ff) - RW'(s7_e1);
   end

   // ------------------------------------------------------------------------
   // stage 8: odd part, saturate, output register
   // ------------------------------------------------------------------------
   logic signed [RW-1:0] s8_r0, s8_r1;
   logic                 s8_fit0, s8_fit1;
   logic [DW-1:0]        s8_f0_in, s8_f1_in, s8_f0_ff, s8_f1_ff;
   logic                 s8_sat_in, s8_sat_ff;

   always_comb begin
      s8_r0   = s7_u0_ff - s7_d_ff;
      s8_r1   = s7_u1_ff + s7_d_ff;
      s8_fit0 = (&s8_r0[RW-1:DW-1]) | ~(|s8_r0[RW-1:DW-1]);
      s8_fit1 = (&s8_r1[RW-1:DW-1]) | ~(|s8_r1[RW-1:DW-1]);
      if (s8_fit0) begin
         s8_f0_in = s8_r0[DW-1:0];
      end else begin
         s8_f0_in = {s8_r0[RW-1], {(DW-1){~s8_r0[RW-1]}}};
      end
      if (s7_rest_ff) begin
         s8_f1_in = '0;
      end else if (s8_fit1) begin
         s8_f1_in = s8_r1[DW-1:0];
      end else begin
         s8_f1_in = {s8_r1[RW-1], {(DW-1){~s8_r1[RW-1]}}};
      end
      // clipping of the unused opposite lane does not count for rest
      s8_sat_in = ~s8_fit0 | (~s7_rest_ff & ~s8_fit1);
   end

   // ------------------------------------------------------------------------
   // payload registers: load whenever the stage may take an item
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_fd_ff   <= s1_fd_in;
         s1_fo_ff   <= s1_fo_in;
         s1_ed_ff   <= s1_ed_in;
         s1_eo_ff   <= s1_eo_in;
         s1_xd_ff   <= s1_xd_in;
         s1_xo_ff   <= s1_xo_in;
         s1_rest_ff <= req_tuser;
      end
      if (rdy[1]) begin
         s2_nd_ff   <= s2_nd_in;
         s2_no_ff   <= s2_no_in;
         s2_sf_ff   <= s2_sf_in;
         s2_df_ff   <= s2_df_in;
         s2_fd_ff   <= s1_fd_ff;
         s2_fo_ff   <= s1_fo_ff;
         s2_xd_ff   <= s1_xd_ff;
         s2_xo_ff   <= s1_xo_ff;
         s2_trt_ff  <= s2_trt_in;
         s2_rest_ff <= s1_rest_ff;
      end
      if (rdy[2]) begin
         for (int j = 0; j < 4; j++) begin
            s3_op_ff[j] <= s3_op_in[j];
            s3_k_ff[j]  <= s3_k_in[j];
         end
         s3_fd_ff   <= s2_fd_ff;
         s3_fo_ff   <= s2_fo_ff;
         s3_trt_ff  <= s2_trt_ff;
         s3_rest_ff <= s2_rest_ff;
      end
      if (rdy[3]) begin
         for (int j = 0; j < 4; j++) begin
            s4_lo_ff[j] <= s4_lo_in[j];
            s4_hi_ff[j] <= s4_hi_in[j];
         end
         s4_fd_ff   <= s3_fd_ff;
         s4_fo_ff   <= s3_fo_ff;
         s4_trt_ff  <= s3_trt_ff;
         s4_rest_ff <= s3_rest_ff;
      end
      if (rdy[4]) begin
         for (int j = 0; j < 4; j++) begin
            s5_p_ff[j] <= s5_p_in[j];
         end
         s5_fd_ff   <= s4_fd_ff;
         s5_fo_ff   <= s4_fo_ff;
         s5_trt_ff  <= s4_trt_ff;
         s5_rest_ff <= s4_rest_ff;
      end
      if (rdy[5]) begin
         s6_t0_ff   <= s6_t0_in;
         s6_t1_ff   <= s6_t1_in;
         s6_fd_ff   <= s5_fd_ff;
         s6_fo_ff   <= s5_fo_ff;
         s6_trt_ff  <= s5_trt_ff;
         s6_rest_ff <= s5_rest_ff;
      end
      if (rdy[6]) begin
         s7_u0_ff   <= s7_u0_in;
         s7_u1_ff   <= s7_u1_in;
         s7_d_ff    <= s7_d_in;
         s7_rest_ff <= s6_rest_ff;
      end
      if (rdy[7]) begin
         s8_f0_ff  <= s8_f0_in;
         s8_f1_ff  <= s8_f1_in;
         s8_sat_ff <= s8_sat_in;
      end
   end

   assign rsp_tdata = RSP_W'({s8_f1_ff, s8_f0_ff});
   assign rsp_tuser = s8_sat_ff;

endmodule
